FILE: rtl/core/skt_pkg.sv
// Package for the sorted key table: request and response word types,
// status and request codes, and the controller-to-datapath command struct.
// No dependencies.
package skt_pkg;

    localparam int KEY_W   = 31;
    localparam int PAY_W   = 64;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO    = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PAY_W-1:0]   removed_payload;
        logic [TOTAL_W-1:0] entry_total;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

FILE: rtl/core/skt_req_if.sv
// Request channel of the sorted key table: valid/ready handshake and one
// request word. Depends on skt_pkg.
interface skt_req_if
    import skt_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/skt_rsp_if.sv
// Response channel of the sorted key table: valid/ready handshake and one
// response word. Depends on skt_pkg.
interface skt_rsp_if
    import skt_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/skt_ctrl.sv
// Controller of the sorted key table: sequences capture and execution of
// one request word and owns the response valid flag. Depends on skt_pkg.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The response register must be free before a new result lands in it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/skt_dp.sv
// Datapath of the sorted key table: a row of key/payload cells with a
// comparator in each, the entry count, and the response register.
// Depends on skt_pkg.
module skt_dp
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  dp_cmd_t cmd,
    input  req_t    in_data,
    output rsp_t    out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] key_reg [CAPACITY];
    logic [PAY_W-1:0] pay_reg [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_t             req_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] ins_at;
    logic [CAPACITY-1:0] del_at;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] first_hit;

    logic             full;
    logic             found;
    logic             key_zero;
    logic             do_ins;
    logic             do_del;
    logic [PAY_W-1:0] hit_payload;

    // Because the filled cells are sorted, each of these masks is a
    // thermometer: ins_at marks every cell at or above the insert point and
    // del_at every cell at or above the first matching entry. Empty cells
    // count as above both points.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign occ[g]    = (CNT_W'(g) < count_reg);
            assign ins_at[g] = !occ[g] || (req_reg.key < key_reg[g]);
            assign del_at[g] = !occ[g] || (key_reg[g] >= req_reg.key);
            assign hit[g]    = occ[g] && (key_reg[g] == req_reg.key);

            if (g == 0)
            begin : g_first
                assign first_hit[g] = hit[g];

                always_ff @(posedge clk)
                begin
                    if (cmd.execute && do_ins && ins_at[g])
                    begin
                        key_reg[g] <= req_reg.key;
                        pay_reg[g] <= req_reg.payload;
                    end
                    else if (cmd.execute && do_del && del_at[g])
                    begin
                        key_reg[g] <= key_reg[g+1];
                        pay_reg[g] <= pay_reg[g+1];
                    end
                end
            end
            else
            begin : g_rest
                // Equal keys sit next to each other, so the oldest match is
                // the one whose lower neighbor does not match.
                assign first_hit[g] = hit[g] && !hit[g-1];

                always_ff @(posedge clk)
                begin
                    if (cmd.execute && do_ins && ins_at[g])
                    begin
                        if (ins_at[g-1])
                        begin
                            key_reg[g] <= key_reg[g-1];
                            pay_reg[g] <= pay_reg[g-1];
                        end
                        else
                        begin
                            key_reg[g] <= req_reg.key;
                            pay_reg[g] <= req_reg.payload;
                        end
                    end
                    else if (cmd.execute && do_del && del_at[g] && (g < CAPACITY - 1))
                    begin
                        key_reg[g] <= key_reg[(g < CAPACITY - 1) ? g + 1 : g];
                        pay_reg[g] <= pay_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_payload = hit_payload | ({PAY_W{first_hit[i]}} & pay_reg[i]);
        end
    end

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = |hit;
    assign key_zero = (req_reg.key == '0);
    assign do_ins   = (req_reg.req_type == REQ_INSERT) && !full;
    assign do_del   = (req_reg.req_type == REQ_DELETE) && !key_zero && found;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_next.removed_payload = do_del ? hit_payload : '0;
        rsp_next.entry_total     = TOTAL_W'(count_next);
        if (req_reg.req_type == REQ_INSERT)
        begin
            rsp_next.status = full ? ST_FULL : ST_DONE;
        end
        else if (key_zero)
        begin
            rsp_next.status = ST_ZERO;
        end
        else if (!found)
        begin
            rsp_next.status = ST_MISSING;
        end
        else
        begin
            rsp_next.status = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_data = rsp_reg;

endmodule

FILE: rtl/core/sorted_key_table.sv
// Sorted key table: up to CAPACITY key/payload entries held in ascending
// key order, with insert and delete-by-key requests.
// Depends on skt_pkg, skt_req_if, skt_rsp_if, skt_ctrl and skt_dp.
//
// Usage: each word on req asks for an insert (req_type 0, key, payload) or
// a delete by key (req_type 1). Every request gives exactly one word on rsp
// with a status, the payload of a deleted entry (zero otherwise) and the
// number of entries held afterwards. Entries with equal keys keep their
// insertion order; a delete takes the oldest of them.
// Timing: a request is captured in the request register when accepted and
// executed once the response register is free; its response is valid right
// after the executing edge. A new request is accepted only after the
// previous one executes; the limit is the single request register feeding
// the cell row, in which every cell compares and shifts in parallel.
// If the receiver stalls, the response waits in its output register; one
// more request may be accepted meanwhile and holds until rsp is free.
// Reset empties the table at once; there is no clearing pass.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);

    dp_cmd_t cmd;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    skt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (req.data),
        .out_data (rsp.data)
    );

endmodule

FILE: bench/skt_table_checker.sv
// Checker for the sorted key table: watches the request and response channels,
// keeps its own copy of the table and compares every response word in order.
// Depends on skt_pkg, skt_req_if and skt_rsp_if.
module skt_table_checker
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    skt_req_if   req,
    skt_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    logic [KEY_W-1:0] table_keys [CAPACITY];
    logic [PAY_W-1:0] table_payloads [CAPACITY];
    int               table_count;
    rsp_t             expected_rsp_q [$];

    // Applies one request to the shadow table and returns the response it gives.
    function automatic rsp_t apply_request(req_t w);
        rsp_t r;
        int   slot;
        int   i;
        bit   found;
        r.status          = ST_DONE;
        r.removed_payload = '0;
        found             = 1'b0;
        slot              = table_count;
        if (w.req_type == REQ_INSERT)
        begin
            if (table_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // The new entry goes after every entry whose key is not greater.
                for (i = 0; i < table_count; i++)
                begin
                    if (!found && w.key < table_keys[i])
                    begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                for (i = table_count; i > slot; i--)
                begin
                    table_keys[i]     = table_keys[i-1];
                    table_payloads[i] = table_payloads[i-1];
                end
                table_keys[slot]     = w.key;
                table_payloads[slot] = w.payload;
                table_count++;
            end
        end
        else if (w.key == '0)
        begin
            r.status = ST_ZERO;
        end
        else
        begin
            for (i = 0; i < table_count; i++)
            begin
                if (!found && table_keys[i] == w.key)
                begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = ST_MISSING;
            end
            else
            begin
                r.removed_payload = table_payloads[slot];
                for (i = slot; i + 1 < table_count; i++)
                begin
                    table_keys[i]     = table_keys[i+1];
                    table_payloads[i] = table_payloads[i+1];
                end
                table_count--;
            end
        end
        r.entry_total = table_count[TOTAL_W-1:0];
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // The response is checked before the request of the same edge is applied,
    // since a word leaving now always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            table_count = 0;
            expected_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected response word, expected none, got %p",
                             $time, rsp.data);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.data.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.data.status);
                    end
                    if (rsp.data.removed_payload !== want.removed_payload)
                    begin
                        fail_count++;
                        $display("%0t: removed_payload expected %h, got %h",
                                 $time, want.removed_payload, rsp.data.removed_payload);
                    end
                    if (rsp.data.entry_total !== want.entry_total)
                    begin
                        fail_count++;
                        $display("%0t: entry_total expected %0d, got %0d",
                                 $time, want.entry_total, rsp.data.entry_total);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_rsp_q.push_back(apply_request(req.data));
            end
            pending <= expected_rsp_q.size();
        end
    end

endmodule

FILE: bench/sorted_key_table_tb.sv
// Top of the sorted key table bench: clock, reset, request stimulus in bursts,
// a stalling response side and the verdict. Depends on skt_pkg, skt_req_if,
// skt_rsp_if, sorted_key_table and skt_table_checker.
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 500;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    logic [15:0] stall_cycle;

    skt_req_if req_ch ();
    skt_rsp_if rsp_ch ();

    sorted_key_table #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    skt_table_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        stall_cycle  = '0;
    end

    // The receiver cycles through stretches of full speed, coin flips,
    // one-in-four acceptance, long stalls and three-in-four acceptance.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[8:6])
            3'd0, 3'd4: rsp_ch.ready <= 1'b1;
            3'd1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            3'd2:       rsp_ch.ready <= (stall_cycle[1:0] == 2'd0);
            3'd3:       rsp_ch.ready <= (stall_cycle[4:0] > 5'd24);
            default:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sends one request word and waits for it to be taken; between bursts the
    // valid line may drop for a random gap.
    task automatic push_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] payload);
        req_t w;
        int   gap;
        w.req_type   = kind;
        w.key        = key;
        w.payload    = payload;
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // Keys come mostly from a small pool so that deletes find their entries
    // and duplicates are common.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return {KEY_W{1'b1}};
        else if (r < 20)
            return KEY_W'($urandom);
        else
            return KEY_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return {PAY_W{1'b1}};
        else
            return {$urandom, $urandom};
    endfunction

    initial
    begin
        int sent;
        int phase;
        int phase_len;
        int insert_pct;
        int i;
        burst_left = $urandom_range(1, 20);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: refusals on an empty table, key zero, the extremes,
        // equal keys leaving oldest first, then a fill up to the full table.
        push_request(REQ_DELETE, 31'd5, '0);
        push_request(REQ_DELETE, 31'd0, '0);
        push_request(REQ_INSERT, 31'd0, '0);
        push_request(REQ_DELETE, 31'd0, {PAY_W{1'b1}});
        push_request(REQ_INSERT, {KEY_W{1'b1}}, {PAY_W{1'b1}});
        push_request(REQ_INSERT, 31'd3, 64'h0123_4567_89ab_cdef);
        push_request(REQ_INSERT, 31'd3, 64'hfedc_ba98_7654_3210);
        push_request(REQ_DELETE, 31'd3, '0);
        push_request(REQ_INSERT, 31'd1, 64'h5555_aaaa_5555_aaaa);
        push_request(REQ_DELETE, {KEY_W{1'b1}}, '0);
        push_request(REQ_DELETE, 31'd3, '0);
        for (i = 0; i < CAPACITY - 2; i++)
        begin
            push_request(REQ_INSERT, KEY_W'(100 - 5 * i), {$urandom, $urandom});
        end
        push_request(REQ_INSERT, 31'd50, {$urandom, $urandom});
        push_request(REQ_DELETE, 31'd77, '0);

        // Random part: phases that lean toward filling or draining the table,
        // so full and empty are both reached many times.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len  = $urandom_range(20, 60);
            insert_pct = (phase % 2 == 0) ? 25 : 80;
            for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                    push_request(REQ_INSERT, pick_key(), pick_payload());
                else
                    push_request(REQ_DELETE, pick_key(), pick_payload());
                sent++;
            end
            phase++;
        end
        req_ch.valid <= 1'b0;

        // The last request must show up in the pending count before it is polled.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_key_table: match");
        else
            $display("sorted_key_table: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sorted_key_table: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/skt_pkg.sv
rtl/core/skt_req_if.sv
rtl/core/skt_rsp_if.sv
rtl/core/skt_ctrl.sv
rtl/core/skt_dp.sv
rtl/core/sorted_key_table.sv
bench/skt_table_checker.sv
bench/sorted_key_table_tb.sv
